>>> hdl/bae_pkg.sv
package bae_pkg;

  // Widest prefix that the encoder emits; longer settings saturate here.
  localparam int PREFIX_MAX = 8;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  // BCH generator terms of the bech32 checksum.
  localparam logic [29:0] GEN [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  // Bech32 character set; character 0 sits in the top byte.
  localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  localparam logic [6:0] CHAR_SEP = 7'h31;  // '1'

  // APB register indexes (paddr[3]).
  localparam logic REG_PREFIX_CHARS  = 1'b0;
  localparam logic REG_PREFIX_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PFX,
    ST_SEP,
    ST_VER,
    ST_DATA,
    ST_PAD,
    ST_FIN,
    ST_CHK
  } bae_state_t;

  typedef struct packed {
    logic [7:0] program_byte;
    logic       final_byte;
    logic       first_byte;
  } bae_entry_t;

  typedef struct packed {
    logic [63:0] prefix_chars;
    logic [3:0]  prefix_length;
  } bae_cfg_t;

  // One step of the BCH polymod: shift in a 5-bit group.
  function automatic logic [29:0] fold(logic [29:0] chk, logic [4:0] v);
    logic [4:0]  top;
    logic [29:0] r;
    top = chk[29:25];
    r   = {chk[24:0], v};
    for (int i = 0; i < 5; i++) begin
      if (top[i]) begin
        r = r ^ GEN[i];
      end
    end
    return r;
  endfunction

  function automatic logic [6:0] char_of(logic [4:0] g);
    logic [7:0] c;
    c = CHARSET[{~g, 3'b000} +: 8];
    return c[6:0];
  endfunction

endpackage

>>> hdl/bae_ifs.sv
interface bae_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] program_byte;
  logic       final_byte;

  modport source (output valid, output program_byte, output final_byte, input ready);
  modport sink (input valid, input program_byte, input final_byte, output ready);
endinterface

interface bae_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       end_of_run;
  logic       end_of_address;

  modport source (output valid, output char_code, output end_of_run,
                  output end_of_address, input ready);
  modport sink (input valid, input char_code, input end_of_run,
                input end_of_address, output ready);
endinterface

>>> hdl/bae_queue.sv
module bae_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bae_pkg::bae_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output bae_pkg::bae_entry_t entry
);

  bae_pkg::bae_entry_t        mem_r [bae_pkg::Q_DEPTH];
  logic [bae_pkg::Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [bae_pkg::Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [bae_pkg::Q_AW:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (bae_pkg::Q_AW+1)'(bae_pkg::Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == bae_pkg::Q_AW'(bae_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == bae_pkg::Q_AW'(bae_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef SYNTH
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue popped while empty");
`endif

endmodule

>>> hdl/bae_front.sv
module bae_front (
  input  logic                clk,
  input  logic                rst_n,
  bae_in_if.sink              in_ch,
  input  logic                q_full,
  output logic                push,
  output bae_pkg::bae_entry_t push_entry
);

  // Set while an address is open, so the next byte is not its first.
  logic in_addr_r, in_addr_nxt;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    push_entry.program_byte = in_ch.program_byte;
    push_entry.final_byte   = in_ch.final_byte;
    push_entry.first_byte   = !in_addr_r;
    in_addr_nxt = in_addr_r;
    if (push) begin
      in_addr_nxt = !in_ch.final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_addr_r <= 1'b0;
    end else begin
      in_addr_r <= in_addr_nxt;
    end
  end

endmodule

>>> hdl/bae_back.sv
module bae_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bae_pkg::bae_cfg_t   cfg,
  input  logic                q_valid,
  input  bae_pkg::bae_entry_t q_entry,
  output logic                q_pop,
  bae_out_if.source           out_ch
);

  bae_pkg::bae_state_t st_r, st_nxt;
  logic        fin_r, fin_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [3:0]  rem_r, rem_nxt;
  logic [3:0]  lo_r, lo_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [29:0] chk_r, chk_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [3:0]  len_r, len_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic [6:0]  out_char_r, out_char_nxt;
  logic        out_eor_r, out_eor_nxt;
  logic        out_eoa_r, out_eoa_nxt;

  logic        adv;
  logic        done;
  logic [3:0]  len_sat;
  logic [3:0]  nb;
  logic [4:0]  grp;
  logic [7:0]  pbyte;
  logic [29:0] chk_tmp;

  function automatic logic [7:0] pfx_byte(logic [63:0] chars, logic [2:0] k);
    return chars[{k, 3'b000} +: 8];
  endfunction

  // Symbol j of the expanded prefix: high bits, a zero, then low bits.
  function automatic logic [4:0] seed_sym(logic [63:0] chars, logic [3:0] len,
                                          logic [4:0] j);
    logic [7:0] b;
    logic [4:0] k;
    logic [4:0] s;
    b = '0;
    k = j - {1'b0, len} - 5'd1;
    if (j < {1'b0, len}) begin
      b = pfx_byte(chars, j[2:0]);
      s = {2'b00, b[7:5]};
    end else if (j == {1'b0, len}) begin
      s = '0;
    end else begin
      b = pfx_byte(chars, k[2:0]);
      s = b[4:0];
    end
    return s;
  endfunction

  assign adv     = !out_vld_r || out_ch.ready;
  assign len_sat = (cfg.prefix_length > 4'(bae_pkg::PREFIX_MAX)) ?
                   4'(bae_pkg::PREFIX_MAX) : cfg.prefix_length;

  always_comb begin
    st_nxt       = st_r;
    fin_nxt      = fin_r;
    acc_nxt      = acc_r;
    rem_nxt      = rem_r;
    lo_nxt       = lo_r;
    cnt_nxt      = cnt_r;
    chk_nxt      = chk_r;
    idx_nxt      = idx_r;
    len_nxt      = len_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_char_nxt = out_char_r;
    out_eor_nxt  = out_eor_r;
    out_eoa_nxt  = out_eoa_r;
    done         = 1'b0;
    q_pop        = 1'b0;
    nb           = rem_r - 4'd5;
    grp          = 5'(acc_r >> nb);
    pbyte        = pfx_byte(cfg.prefix_chars, idx_r);
    chk_tmp      = '0;

    unique case (st_r)
      bae_pkg::ST_IDLE: begin
        done = 1'b1;
      end
      bae_pkg::ST_PFX: begin
        if (adv) begin
          out_vld_nxt = 1'b1; out_char_nxt = pbyte[6:0];
          out_eor_nxt = 1'b0; out_eoa_nxt = 1'b0;
          chk_tmp = bae_pkg::fold(chk_r,
                      seed_sym(cfg.prefix_chars, len_r, {1'b0, idx_r, 1'b0}));
          chk_nxt = bae_pkg::fold(chk_tmp,
                      seed_sym(cfg.prefix_chars, len_r, {1'b0, idx_r, 1'b1}));
          idx_nxt = idx_r + 3'd1;
          if ({1'b0, idx_r} == len_r - 4'd1) begin
            st_nxt = bae_pkg::ST_SEP;
          end
        end
      end
      bae_pkg::ST_SEP: begin
        if (adv) begin
          out_vld_nxt = 1'b1; out_char_nxt = bae_pkg::CHAR_SEP;
          out_eor_nxt = 1'b0; out_eoa_nxt = 1'b0;
          chk_nxt = bae_pkg::fold(chk_r,
                      seed_sym(cfg.prefix_chars, len_r, {len_r, 1'b0}));
          st_nxt  = bae_pkg::ST_VER;
        end
      end
      bae_pkg::ST_VER: begin
        if (adv) begin
          out_vld_nxt = 1'b1; out_char_nxt = bae_pkg::char_of(5'd0);
          out_eor_nxt = 1'b0; out_eoa_nxt = 1'b0;
          chk_nxt = bae_pkg::fold(chk_r, 5'd0);
          st_nxt  = bae_pkg::ST_DATA;
        end
      end
      bae_pkg::ST_DATA: begin
        if (adv) begin
          out_vld_nxt = 1'b1; out_char_nxt = bae_pkg::char_of(grp);
          out_eor_nxt = 1'b0; out_eoa_nxt = 1'b0;
          chk_nxt = bae_pkg::fold(chk_r, grp);
          rem_nxt = nb;
          if (nb < 4'd5) begin
            lo_nxt  = acc_r[3:0] & ~(4'hF << nb);
            cnt_nxt = nb[2:0];
            if (fin_r) begin
              idx_nxt = '0;
              st_nxt  = (nb != 4'd0) ? bae_pkg::ST_PAD : bae_pkg::ST_FIN;
            end else begin
              out_eor_nxt = 1'b1;
              done        = 1'b1;
            end
          end
        end
      end
      bae_pkg::ST_PAD: begin
        if (adv) begin
          grp = 5'({1'b0, lo_r} << (3'd5 - cnt_r));
          out_vld_nxt = 1'b1; out_char_nxt = bae_pkg::char_of(grp);
          out_eor_nxt = 1'b0; out_eoa_nxt = 1'b0;
          chk_nxt = bae_pkg::fold(chk_r, grp);
          idx_nxt = '0;
          st_nxt  = bae_pkg::ST_FIN;
        end
      end
      bae_pkg::ST_FIN: begin
        chk_tmp = bae_pkg::fold(bae_pkg::fold(chk_r, 5'd0), 5'd0);
        chk_nxt = chk_tmp;
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'd2) begin
          chk_nxt = chk_tmp ^ 30'd1;
          idx_nxt = '0;
          st_nxt  = bae_pkg::ST_CHK;
        end
      end
      bae_pkg::ST_CHK: begin
        if (adv) begin
          out_vld_nxt = 1'b1; out_char_nxt = bae_pkg::char_of(chk_r[29:25]);
          out_eor_nxt = 1'b0; out_eoa_nxt = 1'b0;
          chk_nxt = {chk_r[24:0], 5'd0};
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd5) begin
            out_eor_nxt = 1'b1;
            out_eoa_nxt = 1'b1;
            chk_nxt     = 30'd1;
            lo_nxt      = '0;
            cnt_nxt     = '0;
            done        = 1'b1;
          end
        end
      end
      default: begin
        st_nxt = bae_pkg::ST_IDLE;
      end
    endcase

    // Load the next queued byte in the same cycle the current one ends.
    if (done) begin
      if (q_valid) begin
        q_pop   = 1'b1;
        fin_nxt = q_entry.final_byte;
        if (q_entry.first_byte) begin
          lo_nxt  = '0;
          cnt_nxt = '0;
          chk_nxt = 30'd1;
          len_nxt = len_sat;
          idx_nxt = '0;
          st_nxt  = (len_sat == 4'd0) ? bae_pkg::ST_SEP : bae_pkg::ST_PFX;
        end else begin
          st_nxt  = bae_pkg::ST_DATA;
        end
        acc_nxt = {lo_nxt, q_entry.program_byte};
        rem_nxt = {1'b0, cnt_nxt} + 4'd8;
      end else begin
        st_nxt = bae_pkg::ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= bae_pkg::ST_IDLE;
      out_vld_r <= 1'b0;
      lo_r      <= '0;
      cnt_r     <= '0;
      chk_r     <= 30'd1;
      idx_r     <= '0;
    end else begin
      st_r      <= st_nxt;
      out_vld_r <= out_vld_nxt;
      lo_r      <= lo_nxt;
      cnt_r     <= cnt_nxt;
      chk_r     <= chk_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r      <= fin_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    len_r      <= len_nxt;
    out_char_r <= out_char_nxt;
    out_eor_r  <= out_eor_nxt;
    out_eoa_r  <= out_eoa_nxt;
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.char_code      = out_char_r;
  assign out_ch.end_of_run     = out_eor_r;
  assign out_ch.end_of_address = out_eoa_r;

`ifndef SYNTH
  a_eoa_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_eoa_r |-> out_eor_r)
    else $error("end of address without end of run");
  a_data_has_group: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == bae_pkg::ST_DATA |-> rem_r >= 4'd5)
    else $error("regrouping entered with fewer than five bits");
  a_leftover_short: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("leftover count out of range");
`endif

endmodule

>>> hdl/bech32_address_encoder.sv
// Bech32 (segwit version 0) address encoder.
// Witness-program bytes enter on in_ch, one per transfer, with final_byte set on
// the last byte of an address. Address characters leave on out_ch, one per
// transfer, as 7-bit ASCII. end_of_run marks the last character caused by a
// byte and end_of_address the sixth checksum character.
// The first byte of an address also produces the prefix (prefix_chars and
// prefix_length over APB, at byte addresses 0 and 8), then '1' and 'q'.
// The character unit issues one character per cycle while the receiver takes
// them and the queue holds bytes, except while it finishes the checksum: an
// ordinary byte gives one or two characters (one per 5-bit group), the first
// byte of an address adds the prefix characters, '1' and 'q', and the final
// byte adds an optional pad character, six zero BCH folds to finish the
// checksum (two folds per cycle) and six checksum characters.
// A two-entry queue separates input acceptance from character generation and
// an output register holds the pending character, so input transfers continue
// while the receiver stalls until the queue is full. Synchronous reset clears
// all control state, ends any open address and restores the register defaults
// ("bc", length 2); no clearing pass is needed.
module bech32_address_encoder (
  input  logic        clk,
  input  logic        rst_n,
  bae_in_if.sink      in_ch,
  bae_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [63:0] prefix_chars_r, prefix_chars_nxt;
  logic [3:0]  prefix_length_r, prefix_length_nxt;
  logic        cfg_wr;

  bae_pkg::bae_cfg_t   cfg;
  bae_pkg::bae_entry_t push_entry;
  bae_pkg::bae_entry_t q_entry;
  logic                push;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Registers are decoded on paddr[3] alone: 0 selects the prefix characters,
  // 8 selects the prefix length.
  always_comb begin
    prefix_chars_nxt  = prefix_chars_r;
    prefix_length_nxt = prefix_length_r;
    if (cfg_wr) begin
      if (paddr[3] == bae_pkg::REG_PREFIX_CHARS) begin
        prefix_chars_nxt = pwdata;
      end else begin
        prefix_length_nxt = pwdata[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_chars_r  <= 64'h6362;
      prefix_length_r <= 4'd2;
    end else begin
      prefix_chars_r  <= prefix_chars_nxt;
      prefix_length_r <= prefix_length_nxt;
    end
  end

  assign prdata = (paddr[3] == bae_pkg::REG_PREFIX_LENGTH) ?
                  {60'd0, prefix_length_r} : prefix_chars_r;

  assign cfg.prefix_chars  = prefix_chars_r;
  assign cfg.prefix_length = prefix_length_r;

  // Front: accepts bytes and tags the first byte of each address.
  bae_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  bae_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .entry      (q_entry)
  );

  // Back: regroups bits, runs the checksum and issues the characters.
  bae_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
